FILE: hw/rtl/imhq_pkg.sv
// ============================================================================
// imhq_pkg
// Shared types and constants for the indexed min-heap queue.
// ============================================================================
package imhq_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_WIDTH = 48;
  localparam int HANDLES   = 64;
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int HANDLE_W  = $clog2(HANDLES);
  localparam int KEY_W     = KEY_WIDTH;
  localparam int ENT_W     = HANDLE_W + KEY_W;
  localparam int STATUS_W  = 3;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_UPDATE  = 2'd2,
    OP_REMOVE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_RD_A,
    S_RD_WAIT,
    S_CMP,
    S_SWAP,
    S_SWAP_B,
    S_ROOT,
    S_ROOT_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;       // capture request, read position table, root and last slot
    logic apply;      // perform the opcode's initial write
    logic rd_pair;    // read parent and left child
    logic rd_right;   // read right child
    logic do_swap;    // write first half of a swap
    logic do_swap_b;  // write second half of a swap
    logic rd_root;    // read slot 0
    logic fill_out;   // capture result
  } cmd_t;

  typedef struct packed {
    logic    reject;    // request refused, no heap change
    logic    walk;      // a sift is needed
    logic    move;      // comparison says swap
  } stat_t;

endpackage

FILE: hw/rtl/imhq_if.sv
// ============================================================================
// imhq_req_if / imhq_res_if
// Valid/ready channels carrying requests and results.
// ============================================================================
interface imhq_req_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [5:0] task_handle;
  logic [47:0] run_key;
  modport source (output valid, opcode, task_handle, run_key, input ready);
  modport sink   (input valid, opcode, task_handle, run_key, output ready);
endinterface

interface imhq_res_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  taken_handle;
  logic [47:0] taken_key;
  logic [6:0]  entry_count;
  logic        top_valid;
  logic [5:0]  top_handle;
  logic [47:0] top_key;
  modport source (output valid, status, taken_handle, taken_key, entry_count,
                  top_valid, top_handle, top_key, input ready);
  modport sink   (input valid, status, taken_handle, taken_key, entry_count,
                  top_valid, top_handle, top_key, output ready);
endinterface

FILE: hw/rtl/imhq_ctrl.sv
// ============================================================================
// imhq_ctrl
// Sequencer for one request: decide, sift loop, root read, result.
// ============================================================================
module imhq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  imhq_pkg::stat_t stat,
  output imhq_pkg::cmd_t  cmd
);
  import imhq_pkg::*;

  state_t state, state_next;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_valid) state_next = S_DECIDE;
      S_DECIDE:    state_next = stat.reject ? S_ROOT : S_RD_A;
      S_RD_A:      state_next = stat.walk ? S_RD_WAIT : S_ROOT;
      S_RD_WAIT:   state_next = S_CMP;
      S_CMP:       state_next = stat.move ? S_SWAP : S_ROOT;
      S_SWAP:      state_next = S_SWAP_B;
      S_SWAP_B:    state_next = S_RD_A;
      S_ROOT:      state_next = S_ROOT_WAIT;
      S_ROOT_WAIT: state_next = S_OUT;
      S_OUT:       if (!out_valid || out_ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:      cmd.load = in_valid;
      S_DECIDE:    cmd.apply = !stat.reject;
      S_RD_A:      cmd.rd_pair = stat.walk;
      S_RD_WAIT:   cmd.rd_right = 1'b1;
      S_SWAP:      cmd.do_swap = 1'b1;
      S_SWAP_B:    cmd.do_swap_b = 1'b1;
      S_ROOT:      cmd.rd_root = 1'b1;
      S_OUT:       cmd.fill_out = !out_valid || out_ready;
      default:     cmd = '0;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.fill_out)       out_valid <= 1'b1;
      else if (out_ready)     out_valid <= 1'b0;
    end
  end

  // Only one request is in flight.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_swap_pair: assert property (@(posedge clk) disable iff (rst)
    state == S_SWAP |=> state == S_SWAP_B) else $error("half swap");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

FILE: hw/rtl/imhq_dp.sv
// ============================================================================
// imhq_dp
// Heap slot memories, position table, occupancy, sift unit and result.
// ============================================================================
module imhq_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [1:0]                   opcode,
  input  logic [imhq_pkg::HANDLE_W-1:0] task_handle,
  input  logic [imhq_pkg::KEY_W-1:0]   run_key,
  input  imhq_pkg::cmd_t               cmd,
  output imhq_pkg::stat_t              stat,
  output logic [imhq_pkg::STATUS_W-1:0] status,
  output logic [imhq_pkg::HANDLE_W-1:0] taken_handle,
  output logic [imhq_pkg::KEY_W-1:0]   taken_key,
  output logic [6:0]                   entry_count,
  output logic                         top_valid,
  output logic [imhq_pkg::HANDLE_W-1:0] top_handle,
  output logic [imhq_pkg::KEY_W-1:0]   top_key
);
  import imhq_pkg::*;

  // Slot memory: handle and key together.
  logic [ENT_W-1:0] slot_mem [CAPACITY];
  // Position table with present bits.
  logic [SLOT_W-1:0]  pos_tab [HANDLES];
  logic [HANDLES-1:0] present;
  logic [CNT_W-1:0]   occupancy;

  // Request registers.
  opcode_t           op;
  logic [HANDLE_W-1:0] hnd;
  logic [KEY_W-1:0]  key;
  logic [SLOT_W-1:0] hpos;
  status_t           st;
  logic [HANDLE_W-1:0] tk_h;
  logic [KEY_W-1:0]  tk_k;

  // Sift walk registers; mv is the entry being sifted, held at slot cur.
  logic [SLOT_W-1:0] cur;
  logic              dir_up;       // 1 sift up, 0 sift down
  logic              first_step;   // resift decides direction at first compare
  logic              walking;
  logic [SLOT_W-1:0] swap_a;
  logic [ENT_W-1:0]  mv;
  logic [SLOT_W-1:0] tgt;
  logic [ENT_W-1:0]  oth_e;

  // Two registered read ports and one write port on the slot memory.
  logic [ENT_W-1:0]  pa_q, pb_q, rd_l;
  logic              rda_en, rdb_en;
  logic [SLOT_W-1:0] rda_addr, rdb_addr;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [ENT_W-1:0]  wr_data;
  logic              pos_we;
  logic [HANDLE_W-1:0] pos_addr;
  logic [SLOT_W-1:0] pos_data;

  logic [SLOT_W:0] l_idx, r_idx;
  logic [SLOT_W-1:0] p_idx;
  logic [SLOT_W-1:0] last_slot;
  logic l_ok, r_ok;

  logic [KEY_W-1:0] k_cur, k_par, k_l, k_r;
  logic up_move, dn_l, dn_r, dn_move;
  logic go_up;
  status_t st_d;

  assign p_idx = SLOT_W'((cur - 1'b1) >> 1);
  assign l_idx = {cur, 1'b1};
  assign r_idx = {cur, 1'b0} + (SLOT_W+1)'(2);
  assign l_ok  = (CNT_W'(l_idx) < occupancy) && !l_idx[SLOT_W];
  assign r_ok  = ({1'b0, r_idx} < {1'b0, occupancy}) && (r_idx > l_idx);
  assign last_slot = SLOT_W'(occupancy - 1'b1);

  // Comparison between the sifted entry and its neighbours.
  assign k_cur = mv[KEY_W-1:0];
  assign k_par = pa_q[KEY_W-1:0];
  assign k_l   = rd_l[KEY_W-1:0];
  assign k_r   = pb_q[KEY_W-1:0];
  assign up_move = (cur != '0) && (k_par > k_cur);
  assign dn_l    = l_ok && (k_l < k_cur);
  assign dn_r    = r_ok && (dn_l ? (k_r < k_l) : (k_r < k_cur));
  assign dn_move = dn_l || dn_r;

  assign go_up = dir_up || (first_step && up_move);
  assign tgt   = go_up ? p_idx : (dn_r ? r_idx[SLOT_W-1:0] : l_idx[SLOT_W-1:0]);
  assign oth_e = go_up ? pa_q : (dn_r ? pb_q : rd_l);

  always_comb begin
    stat.reject = (st != ST_OK);
    stat.walk   = walking && (CNT_W'(cur) < occupancy);
    stat.move   = go_up ? up_move : dn_move;
  end

  // Request decode into status; a present handle always sits below the occupancy.
  always_comb begin
    st_d = ST_OK;
    case (opcode_t'(opcode))
      OP_INSERT:  if (present[task_handle]) st_d = ST_PRESENT;
                  else if (occupancy >= CNT_W'(CAPACITY)) st_d = ST_FULL;
      OP_EXTRACT: if (occupancy == '0) st_d = ST_EMPTY;
      default:    if (!present[task_handle]) st_d = ST_ABSENT;
    endcase
  end

  // Read addresses: root and last slot at load, parent and left child, then
  // right child, and the root again before the result.
  always_comb begin
    rda_en   = cmd.load || cmd.rd_pair || cmd.rd_root;
    rdb_en   = cmd.load || cmd.rd_pair || cmd.rd_right;
    rda_addr = cmd.rd_pair ? p_idx : '0;
    rdb_addr = last_slot;
    if (cmd.rd_pair) rdb_addr = l_idx[SLOT_W-1:0];
    else if (cmd.rd_right) rdb_addr = r_idx[SLOT_W-1:0];
  end

  // Write port selection for the slot memory and the position table.
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = '0;
    pos_we   = 1'b0;
    pos_addr = '0;
    pos_data = '0;
    if (cmd.apply) begin
      wr_en  = 1'b1;
      pos_we = 1'b1;
      case (op)
        OP_INSERT: begin
          wr_addr  = SLOT_W'(occupancy);
          wr_data  = {hnd, key};
          pos_addr = hnd;
          pos_data = SLOT_W'(occupancy);
        end
        OP_EXTRACT: begin
          wr_addr  = '0;
          wr_data  = pb_q;
          pos_addr = pb_q[ENT_W-1:KEY_W];
          pos_data = '0;
        end
        OP_UPDATE: begin
          wr_addr  = hpos;
          wr_data  = {hnd, key};
          pos_we   = 1'b0;
        end
        default: begin
          wr_addr  = hpos;
          wr_data  = pb_q;
          pos_addr = pb_q[ENT_W-1:KEY_W];
          pos_data = hpos;
        end
      endcase
    end else if (cmd.do_swap) begin
      wr_en    = 1'b1;
      wr_addr  = cur;
      wr_data  = oth_e;
      pos_we   = 1'b1;
      pos_addr = oth_e[ENT_W-1:KEY_W];
      pos_data = cur;
    end else if (cmd.do_swap_b) begin
      wr_en    = 1'b1;
      wr_addr  = swap_a;
      wr_data  = mv;
      pos_we   = 1'b1;
      pos_addr = mv[ENT_W-1:KEY_W];
      pos_data = swap_a;
    end
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (wr_en) slot_mem[wr_addr] <= wr_data;
    if (pos_we) pos_tab[pos_addr] <= pos_data;
    if (rda_en) pa_q <= slot_mem[rda_addr];
    if (rdb_en) pb_q <= slot_mem[rdb_addr];
    if (cmd.rd_right) rd_l <= pb_q;
    if (cmd.load) hpos <= pos_tab[task_handle];
  end

  // Request capture, walk state and result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= opcode_t'(opcode);
      hnd   <= task_handle;
      key   <= run_key;
      st    <= st_d;
      tk_h  <= '0;
      tk_k  <= '0;
      walking <= 1'b0;
      first_step <= 1'b0;
      dir_up <= 1'b0;
    end
    if (cmd.apply) begin
      case (op)
        OP_INSERT: begin
          mv <= {hnd, key};
          cur <= SLOT_W'(occupancy);
          dir_up <= 1'b1;
          walking <= 1'b1;
        end
        OP_EXTRACT: begin
          {tk_h, tk_k} <= pa_q;
          mv <= pb_q;
          cur <= '0;
          walking <= (occupancy > CNT_W'(1));
        end
        OP_UPDATE: begin
          mv <= {hnd, key};
          cur <= hpos;
          first_step <= 1'b1;
          walking <= 1'b1;
        end
        default: begin
          mv <= pb_q;
          cur <= hpos;
          first_step <= 1'b1;
          walking <= (hpos < last_slot);
        end
      endcase
    end
    if (cmd.do_swap) begin
      swap_a <= tgt;
      dir_up <= go_up;
      first_step <= 1'b0;
    end
    if (cmd.do_swap_b) begin
      cur <= swap_a;
    end
    if (cmd.fill_out) begin
      status       <= st;
      taken_handle <= tk_h;
      taken_key    <= tk_k;
      entry_count  <= 7'(occupancy);
      top_valid    <= (occupancy != '0);
      top_handle   <= (occupancy != '0) ? pa_q[ENT_W-1:KEY_W] : '0;
      top_key      <= (occupancy != '0) ? pa_q[KEY_W-1:0] : '0;
    end
  end

  // Control state: presence and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      present   <= '0;
      occupancy <= '0;
    end else if (cmd.apply) begin
      case (op)
        OP_INSERT: begin
          present[hnd] <= 1'b1;
          occupancy    <= occupancy + 1'b1;
        end
        OP_EXTRACT: begin
          present[pa_q[ENT_W-1:KEY_W]] <= 1'b0;
          occupancy <= occupancy - 1'b1;
        end
        OP_REMOVE: begin
          present[hnd] <= 1'b0;
          occupancy    <= occupancy - 1'b1;
        end
        default: occupancy <= occupancy;
      endcase
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CNT_W'(CAPACITY)) else $error("occupancy overflow");
  a_count_present: assert property (@(posedge clk) disable iff (rst)
    $countones(present) == int'(occupancy)) else $error("presence mismatch");
  a_apply_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |-> st == ST_OK) else $error("refused request applied");
endmodule

FILE: hw/rtl/indexed_min_heap_queue.sv
// ============================================================================
// indexed_min_heap_queue
// Indexed binary min-heap of task handles keyed by virtual runtime.
// ============================================================================
// Usage: requests arrive on req (opcode, task_handle, run_key); each gives
// exactly one result on res with a status, any extracted entry, the entry
// count and the root after the step. One request is handled at a time:
// req.ready is high only while the sequencer is idle.
// A refused request goes from the decide step to the root read and the result;
// one that changes the heap without sifting first applies its write. A request
// that sifts then loops per level moved: a slot-memory read of the parent and
// left child, a read of the right child, a compare and a swap written in two
// halves; at 64 entries a sift moves at most 6 levels. The next request is
// taken only after the result has been loaded into the output register.
// Reset clears the presence bits and the occupancy at once; slot contents
// are not cleared, and entries at or above the occupancy are never used.
// When the receiver stalls, the result is held in the output register; one
// further request may be taken and processed, and its result then waits
// until the held one has been taken.
// ============================================================================
module indexed_min_heap_queue (
  input logic         clk,
  input logic         rst,
  imhq_req_if.sink    req,
  imhq_res_if.source  res
);
  import imhq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  imhq_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(res.valid), .out_ready(res.ready),
    .stat(stat), .cmd(cmd)
  );

  imhq_dp u_dp (
    .clk(clk), .rst(rst),
    .opcode(req.opcode), .task_handle(req.task_handle), .run_key(req.run_key),
    .cmd(cmd), .stat(stat),
    .status(res.status), .taken_handle(res.taken_handle),
    .taken_key(res.taken_key), .entry_count(res.entry_count),
    .top_valid(res.top_valid), .top_handle(res.top_handle),
    .top_key(res.top_key)
  );
endmodule
